@@ src/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg: shared definitions for the partition fit allocator
// Opcodes, fit policy codes, register indexes, fixed port widths and the
// control bundles passed between the sequencer, the table and the fit unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

	// Parameter defaults
	localparam int NUM_PARTS_DEF = 16;
	localparam int SIZE_BITS_DEF = 16;
	localparam int ID_BITS_DEF   = 8;

	// Fixed field widths
	localparam int OP_W       = 2;
	localparam int PORT_IDX_W = 4;
	localparam int TOTAL_W    = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int POLICY_W   = 2;
	localparam int PARTS_W    = 5;

	// Request opcodes
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// Fit policies; the spare code behaves as first fit
	localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 2'd1;

	localparam logic [PARTS_W-1:0] PARTS_RESET = 5'd16;

	// Table write strobes
	typedef struct packed {
		logic load_we;
		logic grant_we;
	} tbl_ctrl_t;

	// Fit unit control
	typedef struct packed {
		logic clear;
		logic cand_v;
	} fit_ctrl_t;

endpackage

@@ src/pfa_table.sv @@
// ----------------------------------------------------------------------------
// pfa_table: partition table storage
// Size, leftover and owner memories with one write and one registered read
// port each, plus per-partition used flags cleared by reset.
// ----------------------------------------------------------------------------
module pfa_table #(
	parameter int NUM_PARTS = pfa_pkg::NUM_PARTS_DEF,
	parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
	parameter int ID_BITS   = pfa_pkg::ID_BITS_DEF,
	parameter int IDX_W     = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfa_pkg::tbl_ctrl_t    ctrl,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [SIZE_BITS-1:0]  load_size,
	input  logic [SIZE_BITS-1:0]  grant_left,
	input  logic [ID_BITS-1:0]    grant_owner,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [SIZE_BITS-1:0]  rd_size,
	output logic [SIZE_BITS-1:0]  rd_left,
	output logic [ID_BITS-1:0]    rd_owner,
	output logic [NUM_PARTS-1:0]  used
);

	logic [SIZE_BITS-1:0] size_mem  [NUM_PARTS];
	logic [SIZE_BITS-1:0] left_mem  [NUM_PARTS];
	logic [ID_BITS-1:0]   owner_mem [NUM_PARTS];
	logic [NUM_PARTS-1:0] used_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_we) begin
			size_mem[wr_addr] <= load_size;
		end
		if (ctrl.grant_we) begin
			left_mem[wr_addr]  <= grant_left;
			owner_mem[wr_addr] <= grant_owner;
		end
		rd_size  <= size_mem[rd_addr];
		rd_left  <= left_mem[rd_addr];
		rd_owner <= owner_mem[rd_addr];
	end

	// load frees a partition, grant claims it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (ctrl.load_we) begin
				used_q[wr_addr] <= 1'b0;
			end
			if (ctrl.grant_we) begin
				used_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign used = used_q;

endmodule

@@ src/pfa_fit_unit.sv @@
// ----------------------------------------------------------------------------
// pfa_fit_unit: shared subtract and compare unit for the partition search
// Takes one candidate per cycle and keeps the best one under the fit policy.
// ----------------------------------------------------------------------------
module pfa_fit_unit #(
	parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
	parameter int IDX_W     = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfa_pkg::fit_ctrl_t            ctrl,
	input  logic [pfa_pkg::POLICY_W-1:0]  policy,
	input  logic [IDX_W-1:0]              cand_idx,
	input  logic [SIZE_BITS-1:0]          cand_size,
	input  logic                          cand_free,
	input  logic [SIZE_BITS-1:0]          req_size,
	output logic                          found,
	output logic [IDX_W-1:0]              best_idx,
	output logic [SIZE_BITS-1:0]          best_left
);

	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_left_q;
	logic [SIZE_BITS-1:0] diff;
	logic [SIZE_BITS-1:0] cmp_a;
	logic [SIZE_BITS-1:0] cmp_b;
	logic                 fits;
	logic                 better;
	logic                 take;

	// one comparator, operands swapped between best and worst fit
	always_comb begin
		diff  = cand_size - req_size;
		fits  = cand_free && (cand_size >= req_size);
		cmp_a = (policy == pfa_pkg::POLICY_BEST) ? diff : best_left_q;
		cmp_b = (policy == pfa_pkg::POLICY_BEST) ? best_left_q : diff;
		better = !found_q
			|| (((policy == pfa_pkg::POLICY_BEST) || (policy == pfa_pkg::POLICY_WORST))
				&& (cmp_a < cmp_b));
		take = ctrl.cand_v && fits && better;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= cand_idx;
			best_left_q <= diff;
		end
	end

	assign found     = found_q;
	assign best_idx  = best_idx_q;
	assign best_left = best_left_q;

endmodule

@@ src/partition_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// partition_fit_allocator: fixed partition allocator with first, best and
// worst fit
// Sequencer, configuration registers, running fragmentation total and the
// result register around the partition table and the shared fit unit.
// ----------------------------------------------------------------------------
// The block keeps a table of NUM_PARTS partitions and handles one request at
// a time. A load request sets a partition's size and frees it, a query
// request reports a partition's owner and fragment, and an allocate request
// searches the first partitions_in_use entries (capped at NUM_PARTS) for a
// free one large enough, picking the lowest index (first fit), the smallest
// leftover (best fit) or the largest leftover (worst fit, exact fit allowed),
// ties going to the lowest index. Every request gives exactly one result,
// which carries the total fragment over all used partitions. Load and query
// read the addressed partition through the table's single read port, then
// report; an allocate walks that port one entry a cycle into the shared fit
// unit, lets the fit unit take the last candidate, then reports, and skips
// the search when the search count is zero. The next request can be
// accepted at the edge after the result is registered. in_stall is
// high for the whole of a request; a result waiting in the output register
// does not block the next request until that request is ready to report.
// Configuration writes are always taken and must only happen while the block
// is idle. Every partition that an allocate can reach must have been loaded
// before it is searched.
// ----------------------------------------------------------------------------
module partition_fit_allocator #(
	parameter int NUM_PARTS = pfa_pkg::NUM_PARTS_DEF,
	parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
	parameter int ID_BITS   = pfa_pkg::ID_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data,
	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pfa_pkg::OP_W-1:0]         opcode,
	input  logic [pfa_pkg::PORT_IDX_W-1:0]   part_index,
	input  logic [SIZE_BITS-1:0]             req_size,
	input  logic [ID_BITS-1:0]               proc_id,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             granted,
	output logic [pfa_pkg::PORT_IDX_W-1:0]   chosen_index,
	output logic [SIZE_BITS-1:0]             leftover,
	output logic                             owner_valid,
	output logic [ID_BITS-1:0]               owner,
	output logic [pfa_pkg::TOTAL_W-1:0]      total_fragment
);

	localparam int IDX_W  = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
	localparam int LIM_W  = (IDX_W + 1 > pfa_pkg::PARTS_W) ? IDX_W + 1 : pfa_pkg::PARTS_W;
	localparam int FRAG_W = SIZE_BITS + IDX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DRAIN,
		ST_EXEC
	} state_t;

	state_t                         state_q;

	// configuration
	logic [pfa_pkg::POLICY_W-1:0]   policy_q;
	logic [pfa_pkg::PARTS_W-1:0]    parts_q;

	// captured request
	logic [pfa_pkg::OP_W-1:0]       op_q;
	logic [pfa_pkg::PORT_IDX_W-1:0] idx_q;
	logic                           in_range_q;
	logic [SIZE_BITS-1:0]           size_q;
	logic [ID_BITS-1:0]             pid_q;
	logic [LIM_W-1:0]               n_lim_q;

	// search pointer and read pipeline
	logic [IDX_W-1:0]               addr_q;
	logic                           cand_v_s1;
	logic [IDX_W-1:0]               cand_idx_s1;

	logic [FRAG_W-1:0]              frag_q;
	logic [FRAG_W-1:0]              frag_next;

	// result register
	logic                           out_valid_q;
	logic                           granted_q;
	logic [pfa_pkg::PORT_IDX_W-1:0] chosen_q;
	logic [SIZE_BITS-1:0]           left_q;
	logic                           owner_valid_q;
	logic [ID_BITS-1:0]             owner_q;
	logic [pfa_pkg::TOTAL_W-1:0]    total_q;

	// result fields for the request in hand
	logic                           res_granted;
	logic [pfa_pkg::PORT_IDX_W-1:0] res_chosen;
	logic [SIZE_BITS-1:0]           res_left;
	logic                           res_owner_valid;
	logic [ID_BITS-1:0]             res_owner;

	// table and fit unit connections
	pfa_pkg::tbl_ctrl_t             tbl_ctrl;
	pfa_pkg::fit_ctrl_t             fit_ctrl;
	logic [IDX_W-1:0]               wr_addr;
	logic [SIZE_BITS-1:0]           rd_size;
	logic [SIZE_BITS-1:0]           rd_left;
	logic [ID_BITS-1:0]             rd_owner;
	logic [NUM_PARTS-1:0]           used;
	logic                           found;
	logic [IDX_W-1:0]               best_idx;
	logic [SIZE_BITS-1:0]           best_left;

	logic                           accept;
	logic                           out_free;
	logic                           exec_fire;
	logic                           last_issue;
	logic [IDX_W-1:0]               idx_int;
	logic                           used_at_idx;
	logic [LIM_W-1:0]               n_lim;
	logic                           in_range;

	// ------------------------------------------------------------------------
	// Handshake and decode
	// ------------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign exec_fire = (state_q == ST_EXEC) && out_free;

	// clamp the search count to the table depth
	assign n_lim = (LIM_W'(parts_q) > LIM_W'(NUM_PARTS)) ? LIM_W'(NUM_PARTS) : LIM_W'(parts_q);
	assign in_range = LIM_W'(part_index) < LIM_W'(NUM_PARTS);

	assign idx_int     = IDX_W'(idx_q);
	assign used_at_idx = in_range_q && used[idx_int];
	assign last_issue  = (LIM_W'(addr_q) + LIM_W'(1)) == n_lim_q;

	// ------------------------------------------------------------------------
	// Table and fit unit control
	// ------------------------------------------------------------------------
	always_comb begin
		tbl_ctrl.load_we  = exec_fire && (op_q == pfa_pkg::OP_LOAD) && in_range_q;
		tbl_ctrl.grant_we = exec_fire && (op_q == pfa_pkg::OP_ALLOC) && found;
		wr_addr           = (op_q == pfa_pkg::OP_ALLOC) ? best_idx : idx_int;
		fit_ctrl.clear    = accept;
		fit_ctrl.cand_v   = cand_v_s1;
	end

	// fragmentation total after this request
	always_comb begin
		frag_next = frag_q;
		case (op_q)
			pfa_pkg::OP_LOAD: begin
				if (used_at_idx) begin
					frag_next = frag_q - FRAG_W'(rd_left);
				end
			end
			pfa_pkg::OP_ALLOC: begin
				if (found) begin
					frag_next = frag_q + FRAG_W'(best_left);
				end
			end
			default: begin
			end
		endcase
	end

	// result fields; anything not reported stays zero
	always_comb begin
		res_granted     = 1'b0;
		res_chosen      = '0;
		res_left        = '0;
		res_owner_valid = 1'b0;
		res_owner       = '0;
		case (op_q)
			pfa_pkg::OP_LOAD: begin
				res_chosen = idx_q;
			end
			pfa_pkg::OP_ALLOC: begin
				if (found) begin
					res_granted     = 1'b1;
					res_chosen      = pfa_pkg::PORT_IDX_W'(best_idx);
					res_left        = best_left;
					res_owner_valid = 1'b1;
					res_owner       = pid_q;
				end
			end
			pfa_pkg::OP_QUERY: begin
				res_chosen = idx_q;
				if (used_at_idx) begin
					res_left        = rd_left;
					res_owner_valid = 1'b1;
					res_owner       = rd_owner;
				end
			end
			default: begin
			end
		endcase
	end

	pfa_table #(
		.NUM_PARTS (NUM_PARTS),
		.SIZE_BITS (SIZE_BITS),
		.ID_BITS   (ID_BITS),
		.IDX_W     (IDX_W)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (tbl_ctrl),
		.wr_addr     (wr_addr),
		.load_size   (size_q),
		.grant_left  (best_left),
		.grant_owner (pid_q),
		.rd_addr     (addr_q),
		.rd_size     (rd_size),
		.rd_left     (rd_left),
		.rd_owner    (rd_owner),
		.used        (used)
	);

	pfa_fit_unit #(
		.SIZE_BITS (SIZE_BITS),
		.IDX_W     (IDX_W)
	) u_fit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fit_ctrl),
		.policy    (policy_q),
		.cand_idx  (cand_idx_s1),
		.cand_size (rd_size),
		.cand_free (!used[cand_idx_s1]),
		.req_size  (size_q),
		.found     (found),
		.best_idx  (best_idx),
		.best_left (best_left)
	);

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfa_pkg::POLICY_FIRST;
			parts_q  <= pfa_pkg::PARTS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfa_pkg::CFG_FIT_POLICY:   policy_q <= cfg_data[pfa_pkg::POLICY_W-1:0];
				pfa_pkg::CFG_PARTS_IN_USE: parts_q  <= cfg_data[pfa_pkg::PARTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Request capture
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= opcode;
			idx_q      <= part_index;
			in_range_q <= in_range;
			size_q     <= req_size;
			pid_q      <= proc_id;
			n_lim_q    <= n_lim;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer and result register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			addr_q        <= '0;
			cand_v_s1     <= 1'b0;
			cand_idx_s1   <= '0;
			frag_q        <= '0;
			out_valid_q   <= 1'b0;
			granted_q     <= 1'b0;
			chosen_q      <= '0;
			left_q        <= '0;
			owner_valid_q <= 1'b0;
			owner_q       <= '0;
			total_q       <= '0;
		end else begin
			cand_v_s1 <= (state_q == ST_SCAN);
			// drop the result once it is taken, unless a new one replaces it
			if (out_valid_q && !out_stall && !exec_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == pfa_pkg::OP_ALLOC) begin
							addr_q  <= '0;
							state_q <= (n_lim == '0) ? ST_EXEC : ST_SCAN;
						end else begin
							// point the read port at the addressed partition
							addr_q  <= IDX_W'(part_index);
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_SCAN: begin
					// advance one entry a cycle; the data for an entry shows up in the next cycle
					cand_idx_s1 <= addr_q;
					addr_q      <= addr_q + IDX_W'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// let the fit unit take the last candidate
					addr_q  <= best_idx;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					// hold until the result register can take the result
					if (out_free) begin
						frag_q        <= frag_next;
						out_valid_q   <= 1'b1;
						total_q       <= pfa_pkg::TOTAL_W'(frag_next);
						granted_q     <= res_granted;
						chosen_q      <= res_chosen;
						left_q        <= res_left;
						owner_valid_q <= res_owner_valid;
						owner_q       <= res_owner;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign granted        = granted_q;
	assign chosen_index   = chosen_q;
	assign leftover       = left_q;
	assign owner_valid    = owner_valid_q;
	assign owner          = owner_q;
	assign total_fragment = total_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	// a grant never lands on a partition that is already in use
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && (op_q == pfa_pkg::OP_ALLOC) && found) |-> !used[best_idx])
		else $error("grant to a used partition");

	// the search pointer stays inside the clamped search range
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (LIM_W'(addr_q) < n_lim_q))
		else $error("search pointer beyond range");

	// the fragmentation total moves only when a request reports
	a_frag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_fire |=> $stable(frag_q))
		else $error("fragment total changed outside commit");

	// a new result only comes from the commit step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(exec_fire))
		else $error("result raised without commit");

	// a granted result always names an owner
	a_grant_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && granted_q) |-> owner_valid_q)
		else $error("granted result without owner");

endmodule

@@ dv/partition_fit_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// partition_fit_allocator_tb: self-checking bench for the partition allocator
// Drives load, allocate, query and spare requests, then compares every result
// against a cycle-free model of the partition table kept in a scoreboard.
// ----------------------------------------------------------------------------
// Flow: reset, load all sixteen partitions so that no search ever reads an
// unloaded size, run a directed set over the corner cases (exact fit, worst
// fit exact fit, no fit, search count zero and saturated, spare policy and
// spare opcode, reload of a used partition), then random phases, each under
// its own fit policy and search count. Register writes happen only once the
// block has drained. Both channels idle in short random bursts, except in
// quiet phases and the final phase.
// ----------------------------------------------------------------------------
module partition_fit_allocator_tb;

	localparam int NPARTS = pfa_pkg::NUM_PARTS_DEF;
	localparam int SZ_W   = pfa_pkg::SIZE_BITS_DEF;
	localparam int ID_W   = pfa_pkg::ID_BITS_DEF;

	// Codes the package leaves unnamed
	localparam logic [pfa_pkg::OP_W-1:0]     OP_SPARE     = 2'd3;
	localparam logic [pfa_pkg::POLICY_W-1:0] POLICY_SPARE = 2'd3;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int LONG_HOLD   = 90;
	localparam int DRAIN_WAIT  = 25;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic                           granted;
		logic [pfa_pkg::PORT_IDX_W-1:0] chosen_index;
		logic [SZ_W-1:0]                leftover;
		logic                           owner_valid;
		logic [ID_W-1:0]                owner;
		logic [pfa_pkg::TOTAL_W-1:0]    total_fragment;
	} alloc_result_t;

	// Partition table model and queue of expected results
	class alloc_scoreboard;
		bit [SZ_W-1:0]              size_tab[NPARTS];
		bit                         used_tab[NPARTS];
		bit [ID_W-1:0]              owner_tab[NPARTS];
		bit [SZ_W-1:0]              left_tab[NPARTS];
		bit [pfa_pkg::TOTAL_W:0]    frag_sum;
		bit [pfa_pkg::POLICY_W-1:0] policy;
		bit [pfa_pkg::PARTS_W-1:0]  search_count;
		alloc_result_t              expected_q[$];
		int unsigned n_alloc, n_granted, n_load, n_query, n_checked, n_errors;

		function new();
			foreach (used_tab[i])
				used_tab[i] = 1'b0;
			frag_sum     = '0;
			policy       = pfa_pkg::POLICY_FIRST;
			search_count = pfa_pkg::PARTS_RESET;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(logic [pfa_pkg::OP_W-1:0] op,
				logic [pfa_pkg::PORT_IDX_W-1:0] idx,
				logic [SZ_W-1:0] size, logic [ID_W-1:0] pid);
			alloc_result_t r;
			int            limit;
			bit            found;
			int            best;
			bit [SZ_W-1:0] best_left;
			bit [SZ_W-1:0] gap;
			r     = '0;
			found = 1'b0;
			best  = 0;
			best_left = '0;
			case (op)
				pfa_pkg::OP_LOAD: begin
					n_load++;
					if (used_tab[idx])
						frag_sum -= left_tab[idx];
					size_tab[idx] = size;
					used_tab[idx] = 1'b0;
					left_tab[idx] = '0;
					r.chosen_index = idx;
				end
				pfa_pkg::OP_ALLOC: begin
					n_alloc++;
					limit = (search_count > NPARTS) ? NPARTS : search_count;
					for (int j = 0; j < limit; j++) begin
						if (used_tab[j] || size_tab[j] < size)
							continue;
						gap = size_tab[j] - size;
						if (!found) begin
							found     = 1'b1;
							best      = j;
							best_left = gap;
							if (policy != pfa_pkg::POLICY_BEST &&
									policy != pfa_pkg::POLICY_WORST)
								break;
						end else if (policy == pfa_pkg::POLICY_BEST && gap < best_left) begin
							best      = j;
							best_left = gap;
						end else if (policy == pfa_pkg::POLICY_WORST && gap > best_left) begin
							best      = j;
							best_left = gap;
						end
					end
					if (found) begin
						n_granted++;
						used_tab[best]  = 1'b1;
						owner_tab[best] = pid;
						left_tab[best]  = best_left;
						frag_sum       += best_left;
						r.granted      = 1'b1;
						r.chosen_index = best[pfa_pkg::PORT_IDX_W-1:0];
						r.leftover     = best_left;
						r.owner_valid  = 1'b1;
						r.owner        = pid;
					end
				end
				pfa_pkg::OP_QUERY: begin
					n_query++;
					r.chosen_index = idx;
					if (used_tab[idx]) begin
						r.leftover    = left_tab[idx];
						r.owner_valid = 1'b1;
						r.owner       = owner_tab[idx];
					end
				end
				default: ;
			endcase
			r.total_fragment = frag_sum[pfa_pkg::TOTAL_W-1:0];
			expected_q.push_back(r);
		endfunction

		function bit field_differs(string name, longint unsigned want, longint unsigned seen);
			if (want == seen)
				return 1'b0;
			$error("%s mismatch: expected %0d, got %0d", name, want, seen);
			return 1'b1;
		endfunction

		function void check_result(alloc_result_t seen);
			alloc_result_t want;
			bit            bad;
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding");
				n_errors++;
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			bad = 1'b0;
			bad |= field_differs("granted", want.granted, seen.granted);
			bad |= field_differs("chosen_index", want.chosen_index, seen.chosen_index);
			bad |= field_differs("leftover", want.leftover, seen.leftover);
			bad |= field_differs("owner_valid", want.owner_valid, seen.owner_valid);
			bad |= field_differs("owner", want.owner, seen.owner);
			bad |= field_differs("total_fragment", want.total_fragment, seen.total_fragment);
			if (bad)
				n_errors++;
		endfunction
	endclass

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// Block inputs, all known from time zero
	logic                           cfg_valid = 1'b0;
	logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic [pfa_pkg::OP_W-1:0]       opcode = '0;
	logic [pfa_pkg::PORT_IDX_W-1:0] part_index = '0;
	logic [SZ_W-1:0]                req_size = '0;
	logic [ID_W-1:0]                proc_id = '0;
	logic                           out_stall = 1'b0;

	// Block outputs
	logic                           cfg_ready;
	logic                           in_stall;
	logic                           out_valid;
	logic                           granted;
	logic [pfa_pkg::PORT_IDX_W-1:0] chosen_index;
	logic [SZ_W-1:0]                leftover;
	logic                           owner_valid;
	logic [ID_W-1:0]                owner;
	logic [pfa_pkg::TOTAL_W-1:0]    total_fragment;

	partition_fit_allocator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.part_index     (part_index),
		.req_size       (req_size),
		.proc_id        (proc_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted        (granted),
		.chosen_index   (chosen_index),
		.leftover       (leftover),
		.owner_valid    (owner_valid),
		.owner          (owner),
		.total_fragment (total_fragment)
	);

	alloc_scoreboard sb;

	// Idle percentages per side; zero means no idling at all
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          long_hold_req = 1'b0;
	int unsigned n_cfg_writes = 0;

	// Sample both channels at the edge; payloads are driven by NBA, so the
	// values seen here are the ones the block sees at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(opcode, part_index, req_size, proc_id);
			if (out_valid && !out_stall)
				sb.check_result(alloc_result_t'{granted, chosen_index, leftover,
					owner_valid, owner, total_fragment});
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					quiet_cycles, sb.pending());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request so
	// the output register stays full and the block backs up into in_stall.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one request and hold it until the block takes it; in_valid stays
	// high on return so back-to-back requests need no extra step.
	task automatic send_request(logic [pfa_pkg::OP_W-1:0] op,
			logic [pfa_pkg::PORT_IDX_W-1:0] idx,
			logic [SZ_W-1:0] size, logic [ID_W-1:0] pid);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		part_index <= idx;
		req_size   <= size;
		proc_id    <= pid;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drop the request line and wait for every expected result to arrive;
	// step one edge first so the last accepted request is in the model.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Write one register once the block is idle, and mirror it in the model
	task automatic write_cfg(logic [pfa_pkg::CFG_IDX_W-1:0] idx,
			logic [pfa_pkg::CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == pfa_pkg::CFG_FIT_POLICY)
			sb.policy = data[pfa_pkg::POLICY_W-1:0];
		else if (idx == pfa_pkg::CFG_PARTS_IN_USE)
			sb.search_count = data;
		n_cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One random request: mostly sizes in a band where partitions fit, with
	// exact fits against the current table and full-range values mixed in.
	task automatic send_random();
		int unsigned      pick;
		int unsigned      sz_pick;
		logic [SZ_W-1:0]  size;
		pick    = $urandom_range(99);
		sz_pick = $urandom_range(99);
		if (pick < 40) begin
			if (sz_pick < 70)
				size = SZ_W'($urandom_range(0, 3000));
			else if (sz_pick < 85)
				size = sb.size_tab[$urandom_range(NPARTS - 1)];
			else
				size = SZ_W'($urandom);
			send_request(pfa_pkg::OP_ALLOC, pfa_pkg::PORT_IDX_W'($urandom), size,
				ID_W'($urandom));
		end else if (pick < 65) begin
			size = (sz_pick < 75) ? SZ_W'($urandom_range(0, 4000)) : SZ_W'($urandom);
			send_request(pfa_pkg::OP_LOAD, pfa_pkg::PORT_IDX_W'($urandom), size,
				ID_W'($urandom));
		end else if (pick < 95) begin
			send_request(pfa_pkg::OP_QUERY, pfa_pkg::PORT_IDX_W'($urandom),
				SZ_W'($urandom), ID_W'($urandom));
		end else begin
			send_request(OP_SPARE, pfa_pkg::PORT_IDX_W'($urandom),
				SZ_W'($urandom), ID_W'($urandom));
		end
	endtask

	// Register plan for the random phases: every policy code, search counts
	// at zero, one, full and above the table size.
	logic [pfa_pkg::POLICY_W-1:0] policy_plan[PHASES] = '{pfa_pkg::POLICY_FIRST,
		pfa_pkg::POLICY_BEST, pfa_pkg::POLICY_WORST, POLICY_SPARE, pfa_pkg::POLICY_BEST,
		pfa_pkg::POLICY_WORST, pfa_pkg::POLICY_FIRST, pfa_pkg::POLICY_BEST};
	logic [pfa_pkg::PARTS_W-1:0] count_plan[PHASES] = '{5'd16, 5'd16, 5'd16, 5'd12,
		5'd1, 5'd31, 5'd0, 5'd16};

	logic [SZ_W-1:0] boot_sizes[NPARTS] = '{16'd100, 16'hFFFF, 16'd0, 16'd500, 16'd200,
		16'd1000, 16'd300, 16'd50, 16'h5555, 16'hAAAA, 16'd2500, 16'd75, 16'd1,
		16'd4096, 16'd800, 16'd640};

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Load every partition first: no search may ever read
		// a size that was never written.
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		for (int i = 0; i < NPARTS; i++)
			send_request(pfa_pkg::OP_LOAD, pfa_pkg::PORT_IDX_W'(i), boot_sizes[i], '0);
		// first fit takes the lowest index, then an exact fit of the largest
		send_request(pfa_pkg::OP_ALLOC, '0, '0, '0);
		send_request(pfa_pkg::OP_ALLOC, '0, 16'hFFFF, 8'hFF);
		// nothing left that large
		send_request(pfa_pkg::OP_ALLOC, '0, 16'hFFFF, 8'h01);
		// used, free and top-index queries
		send_request(pfa_pkg::OP_QUERY, 4'd0, '0, '0);
		send_request(pfa_pkg::OP_QUERY, 4'd2, 16'hFFFF, 8'hFF);
		send_request(pfa_pkg::OP_QUERY, 4'hF, '0, '0);
		send_request(OP_SPARE, 4'hF, 16'hFFFF, 8'hFF);
		// reload a used partition: it is freed and its fragment leaves the total
		send_request(pfa_pkg::OP_LOAD, 4'd0, 16'd700, 8'hFF);
		write_cfg(pfa_pkg::CFG_FIT_POLICY, pfa_pkg::CFG_DATA_W'(pfa_pkg::POLICY_BEST));
		send_request(pfa_pkg::OP_ALLOC, '0, 16'd150, 8'hA5);
		// worst fit with only an exact candidate in range
		write_cfg(pfa_pkg::CFG_FIT_POLICY, pfa_pkg::CFG_DATA_W'(pfa_pkg::POLICY_WORST));
		write_cfg(pfa_pkg::CFG_PARTS_IN_USE, 5'd1);
		send_request(pfa_pkg::OP_ALLOC, '0, 16'd700, 8'h5A);
		// nothing searched
		write_cfg(pfa_pkg::CFG_PARTS_IN_USE, 5'd0);
		send_request(pfa_pkg::OP_ALLOC, '0, '0, 8'h33);
		// count above the table size saturates; spare policy acts as first fit
		write_cfg(pfa_pkg::CFG_PARTS_IN_USE, 5'd31);
		write_cfg(pfa_pkg::CFG_FIT_POLICY, pfa_pkg::CFG_DATA_W'(POLICY_SPARE));
		send_request(pfa_pkg::OP_ALLOC, '0, 16'd60, 8'h03);

		// Random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			write_cfg(pfa_pkg::CFG_FIT_POLICY, pfa_pkg::CFG_DATA_W'(policy_plan[ph]));
			write_cfg(pfa_pkg::CFG_PARTS_IN_USE, count_plan[ph]);
			// every third phase and the last one run without idling
			tx_idle_pct = (ph % 3 == 1 || ph == PHASES - 1) ? 0 : 30;
			rx_idle_pct = tx_idle_pct;
			// hold the result side off while requests keep coming
			if (ph == 2)
				long_hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// pause the sender until the block has fully drained
				if (ph == 4 && k == PHASE_ITEMS / 2)
					wait_drained();
				send_random();
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d allocates (%0d granted), %0d loads, %0d queries, %0d register writes",
			sb.n_alloc, sb.n_granted, sb.n_load, sb.n_query, n_cfg_writes);
		$display("Checked %0d results, %0d with mismatches, %0d left outstanding",
			sb.n_checked, sb.n_errors, sb.pending());
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
src/pfa_pkg.sv
src/pfa_table.sv
src/pfa_fit_unit.sv
src/partition_fit_allocator.sv
dv/partition_fit_allocator_tb.sv
